// ----- rtl/core/bycc_pkg.sv -----
// ----------------------------------------------------------------------------
// bycc_pkg: shared types, constants and helpers of the colour converter
// Holds the item structures, the pipeline control bundle, the BT.601 integer
// coefficients and the reciprocal constants used for the divisions by constants.
// ----------------------------------------------------------------------------
package bycc_pkg;

	localparam int NumStages = 5;

	typedef enum logic {
		FuncFwd = 1'b0,
		FuncInv = 1'b1
	} bycc_func_t;

	typedef struct packed {
		logic       func;
		logic [7:0] in_c0;
		logic [7:0] in_c1;
		logic [7:0] in_c2;
	} bycc_pixel_t;

	typedef struct packed {
		logic [7:0] out_c0;
		logic [7:0] out_c1;
		logic [7:0] out_c2;
	} bycc_result_t;

	typedef struct packed {
		logic [NumStages-1:0] en;
		bycc_func_t           func;
	} bycc_ctrl_t;

	// Forward coefficients, scaled by 1000.
	localparam int CoefR     = 299;
	localparam int CoefG     = 587;
	localparam int CoefB     = 114;
	localparam int CrCoef    = 713;
	localparam int CbCoef    = 564;
	localparam int Scale     = 1000;
	localparam int ChromaOfs = 128;
	localparam int LumaMin   = 16;
	localparam int LumaMax   = 235;
	localparam int ChromaMin = 16;
	localparam int ChromaMax = 240;
	localparam int PixMin    = 0;
	localparam int PixMax    = 255;

	// A quotient floor(n / d) for n < 2**a and d < 2**b is exactly
	// (n * ceil(2**(a+b) / d)) >> (a+b).
	localparam int FwdShift = 28;
	localparam logic [18:0] FwdRecip =
		19'(((64'd1 << FwdShift) + 64'(Scale) - 64'd1) / 64'(Scale));

	localparam int RbShift = 27;
	localparam logic [17:0] RecipCr =
		18'(((64'd1 << RbShift) + 64'(CrCoef) - 64'd1) / 64'(CrCoef));
	localparam logic [17:0] RecipCb =
		18'(((64'd1 << RbShift) + 64'(CbCoef) - 64'd1) / 64'(CbCoef));

	// Green terms: 114000/331068 and 299000/418531 reduced by their common factors.
	localparam int GeNum  = 9500;
	localparam int GeDen  = 27589;
	localparam int GdNum  = 13000;
	localparam int GdDen  = 18197;
	localparam int GShift = 36;
	localparam logic [21:0] RecipGe =
		22'(((64'd1 << GShift) + 64'(GeDen) - 64'd1) / 64'(GeDen));
	localparam logic [21:0] RecipGd =
		22'(((64'd1 << GShift) + 64'(GdDen) - 64'd1) / 64'(GdDen));

	function automatic logic signed [10:0] apply_sign(input logic neg, input logic [7:0] mag);
		logic signed [10:0] m;
		m = $signed({3'b000, mag});
		return neg ? -m : m;
	endfunction

	function automatic logic [7:0] clamp_u8(input logic signed [10:0] v,
		input logic [7:0] lo, input logic [7:0] hi);
		logic signed [10:0] lo_s;
		logic signed [10:0] hi_s;
		lo_s = $signed({3'b000, lo});
		hi_s = $signed({3'b000, hi});
		if (v < lo_s) begin
			return lo;
		end else if (v > hi_s) begin
			return hi;
		end
		return v[7:0];
	endfunction

endpackage

// ----- rtl/core/bycc_stream_if.sv -----
// ----------------------------------------------------------------------------
// bycc_stream_if: valid/ready channel carrying one item
// The payload type is chosen where the channel is instantiated.
// ----------------------------------------------------------------------------
interface bycc_stream_if import bycc_pkg::*; #(
	parameter type T = bycc_pixel_t
) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/core/bycc_pipe_ctrl.sv -----
// ----------------------------------------------------------------------------
// bycc_pipe_ctrl: valid tracking and stage enables of the conversion pipeline
// A stage loads whenever it is empty or its successor loads, so bubbles close up.
// ----------------------------------------------------------------------------
module bycc_pipe_ctrl import bycc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       func,
	output logic       out_valid,
	input  logic       out_ready,
	output bycc_ctrl_t ctrl
);

	logic [NumStages-1:0] vld_q;
	logic [NumStages-1:0] func_q;
	logic [NumStages:0]   rdy;
	logic [NumStages-1:0] vld_prev;
	logic [NumStages-1:0] func_prev;

	always_comb begin
		rdy[NumStages] = out_ready;
		for (int i = NumStages - 1; i >= 0; i--) begin
			rdy[i] = !vld_q[i] || rdy[i+1];
		end
	end

	assign vld_prev  = {vld_q[NumStages-2:0], in_valid};
	assign func_prev = {func_q[NumStages-2:0], func};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < NumStages; i++) begin
				if (rdy[i]) begin
					vld_q[i] <= vld_prev[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NumStages; i++) begin
			if (rdy[i]) begin
				func_q[i] <= func_prev[i];
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_q[NumStages-1];
	assign ctrl.en   = rdy[NumStages-1:0];
	assign ctrl.func = bycc_func_t'(func_q[NumStages-1]);

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted item did not reach the first stage");

	a_empty_tail_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[NumStages-1] |-> in_ready)
		else $error("input stalled although the last stage is empty");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(&vld_q) && !out_ready |-> !in_ready)
		else $error("input taken while the pipeline is full and stalled");

endmodule

// ----- rtl/core/bycc_fwd.sv -----
// ----------------------------------------------------------------------------
// bycc_fwd: BGR to YCrCb datapath
// Weighted sum, luma by reciprocal, chroma products, chroma quotients, clamp.
// ----------------------------------------------------------------------------
module bycc_fwd import bycc_pkg::*; (
	input  logic                 clk,
	input  logic [NumStages-1:0] en,
	input  bycc_pixel_t          pixel,
	output bycc_result_t         res
);

	logic [17:0] sum_s1;
	logic [7:0]  blu_s1, red_s1;
	logic [7:0]  luma_s2, blu_s2, red_s2;
	logic [17:0] prod_cr_s3, prod_cb_s3;
	logic        neg_cr_s3, neg_cb_s3;
	logic [7:0]  luma_s3;
	logic [7:0]  q_cr_s4, q_cb_s4;
	logic        neg_cr_s4, neg_cb_s4;
	logic [7:0]  luma_s4;
	bycc_result_t res_s5;

	logic [36:0] luma_prod;
	logic [8:0]  dr, db;
	logic [7:0]  mag_r, mag_b;
	logic [36:0] cr_prod, cb_prod;
	logic signed [10:0] cr_v, cb_v;

	// Stage 1: luma numerator scaled by 1000.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			sum_s1 <= 18'(pixel.in_c2) * 18'(CoefR) + 18'(pixel.in_c1) * 18'(CoefG)
				+ 18'(pixel.in_c0) * 18'(CoefB);
			blu_s1 <= pixel.in_c0;
			red_s1 <= pixel.in_c2;
		end
	end

	// Stage 2: divide by 1000.
	assign luma_prod = 37'(sum_s1) * 37'(FwdRecip);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			luma_s2 <= 8'(luma_prod >> FwdShift);
			blu_s2  <= blu_s1;
			red_s2  <= red_s1;
		end
	end

	// Stage 3: colour differences as sign and magnitude, times the chroma gains.
	assign dr    = {1'b0, red_s2} - {1'b0, luma_s2};
	assign db    = {1'b0, blu_s2} - {1'b0, luma_s2};
	assign mag_r = dr[8] ? 8'(-dr) : dr[7:0];
	assign mag_b = db[8] ? 8'(-db) : db[7:0];

	always_ff @(posedge clk) begin
		if (en[2]) begin
			prod_cr_s3 <= 18'(mag_r) * 18'(CrCoef);
			prod_cb_s3 <= 18'(mag_b) * 18'(CbCoef);
			neg_cr_s3  <= dr[8];
			neg_cb_s3  <= db[8];
			luma_s3    <= luma_s2;
		end
	end

	// Stage 4: magnitudes divided by 1000, so the quotient truncates toward zero.
	assign cr_prod = 37'(prod_cr_s3) * 37'(FwdRecip);
	assign cb_prod = 37'(prod_cb_s3) * 37'(FwdRecip);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			q_cr_s4   <= 8'(cr_prod >> FwdShift);
			q_cb_s4   <= 8'(cb_prod >> FwdShift);
			neg_cr_s4 <= neg_cr_s3;
			neg_cb_s4 <= neg_cb_s3;
			luma_s4   <= luma_s3;
		end
	end

	// Stage 5: restore sign, add the offset and clamp to the video ranges.
	assign cr_v = $signed(11'(ChromaOfs)) + apply_sign(neg_cr_s4, q_cr_s4);
	assign cb_v = $signed(11'(ChromaOfs)) + apply_sign(neg_cb_s4, q_cb_s4);

	always_ff @(posedge clk) begin
		if (en[4]) begin
			res_s5.out_c0 <= clamp_u8($signed({3'b000, luma_s4}), 8'(LumaMin), 8'(LumaMax));
			res_s5.out_c1 <= clamp_u8(cr_v, 8'(ChromaMin), 8'(ChromaMax));
			res_s5.out_c2 <= clamp_u8(cb_v, 8'(ChromaMin), 8'(ChromaMax));
		end
	end

	assign res = res_s5;

endmodule

// ----- rtl/core/bycc_inv.sv -----
// ----------------------------------------------------------------------------
// bycc_inv: YCrCb to BGR datapath
// Chroma products, quotients by reciprocal, channel sums, clamp, output stage.
// ----------------------------------------------------------------------------
module bycc_inv import bycc_pkg::*; (
	input  logic                 clk,
	input  logic [NumStages-1:0] en,
	input  bycc_pixel_t          pixel,
	output bycc_result_t         res
);

	logic [16:0] prod_r_s1, prod_b_s1;
	logic [20:0] prod_gd_s1, prod_ge_s1;
	logic        neg_d_s1, neg_e_s1;
	logic [7:0]  luma_s1;
	logic [7:0]  q_r_s2, q_b_s2, q_gd_s2, q_ge_s2;
	logic        neg_d_s2, neg_e_s2;
	logic [7:0]  luma_s2;
	logic signed [10:0] red_s3, grn_s3, blu_s3;
	bycc_result_t res_s4, res_s5;

	logic        neg_d, neg_e;
	logic [7:0]  mag_d, mag_e;
	logic [34:0] r_prod, b_prod;
	logic [42:0] gd_prod, ge_prod;
	logic signed [10:0] luma_v;

	// Stage 1: chroma minus 128 as sign and magnitude, times the numerators.
	assign neg_d = ~pixel.in_c1[7];
	assign neg_e = ~pixel.in_c2[7];
	assign mag_d = pixel.in_c1[7] ? {1'b0, pixel.in_c1[6:0]} : 8'(8'(ChromaOfs) - pixel.in_c1);
	assign mag_e = pixel.in_c2[7] ? {1'b0, pixel.in_c2[6:0]} : 8'(8'(ChromaOfs) - pixel.in_c2);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			prod_r_s1  <= 17'(mag_d) * 17'(Scale);
			prod_gd_s1 <= 21'(mag_d) * 21'(GdNum);
			prod_b_s1  <= 17'(mag_e) * 17'(Scale);
			prod_ge_s1 <= 21'(mag_e) * 21'(GeNum);
			neg_d_s1   <= neg_d;
			neg_e_s1   <= neg_e;
			luma_s1    <= pixel.in_c0;
		end
	end

	// Stage 2: quotients of the magnitudes, each truncated on its own.
	assign r_prod  = 35'(prod_r_s1) * 35'(RecipCr);
	assign b_prod  = 35'(prod_b_s1) * 35'(RecipCb);
	assign gd_prod = 43'(prod_gd_s1) * 43'(RecipGd);
	assign ge_prod = 43'(prod_ge_s1) * 43'(RecipGe);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			q_r_s2   <= 8'(r_prod >> RbShift);
			q_b_s2   <= 8'(b_prod >> RbShift);
			q_gd_s2  <= 8'(gd_prod >> GShift);
			q_ge_s2  <= 8'(ge_prod >> GShift);
			neg_d_s2 <= neg_d_s1;
			neg_e_s2 <= neg_e_s1;
			luma_s2  <= luma_s1;
		end
	end

	// Stage 3: channel sums, unclamped.
	assign luma_v = $signed({3'b000, luma_s2});

	always_ff @(posedge clk) begin
		if (en[2]) begin
			red_s3 <= luma_v + apply_sign(neg_d_s2, q_r_s2);
			blu_s3 <= luma_v + apply_sign(neg_e_s2, q_b_s2);
			grn_s3 <= luma_v - apply_sign(neg_e_s2, q_ge_s2) - apply_sign(neg_d_s2, q_gd_s2);
		end
	end

	// Stage 4: clamp to the full sample range.
	always_ff @(posedge clk) begin
		if (en[3]) begin
			res_s4.out_c0 <= clamp_u8(blu_s3, 8'(PixMin), 8'(PixMax));
			res_s4.out_c1 <= clamp_u8(grn_s3, 8'(PixMin), 8'(PixMax));
			res_s4.out_c2 <= clamp_u8(red_s3, 8'(PixMin), 8'(PixMax));
		end
	end

	// Stage 5: output register, level with the forward path.
	always_ff @(posedge clk) begin
		if (en[4]) begin
			res_s5 <= res_s4;
		end
	end

	assign res = res_s5;

endmodule

// ----- rtl/core/bgr_ycrcb_color_convert.sv -----
// ----------------------------------------------------------------------------
// bgr_ycrcb_color_convert: BT.601 style colour conversion, both directions
// Five-stage pipeline converting one 8-bit three-channel pixel per clock unless stalled.
// ----------------------------------------------------------------------------
// Usage:
// The pixel channel carries one item per handshake: a direction bit (func) and
// three 8-bit samples. With func low the samples are blue, green and red and
// the result is Y, Cr and Cb clamped to the video ranges; with func high the
// samples are Y, Cr and Cb and the result is blue, green and red clamped to
// 0..255. The result channel returns exactly one item per accepted item, in
// order. Both directions are computed side by side and the direction bit,
// carried along with the item, picks the result behind the output registers.
// The block takes one item every cycle while the receiver keeps taking results;
// the five register stages each hold about one level of logic (weighted sum,
// divide by reciprocal, chroma product, divide by reciprocal, clamp).
// Reset empties the pipeline: all stage valid bits clear and the pixel
// channel is ready straight away. When the receiver stalls, the last stage
// holds its item, and earlier stages keep filling until every stage is
// occupied; only then does the pixel channel drop ready. No item is lost or
// repeated across a stall.
// ----------------------------------------------------------------------------
module bgr_ycrcb_color_convert import bycc_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	bycc_stream_if.sink    pixel,
	bycc_stream_if.source  result
);

	bycc_ctrl_t   ctrl;
	bycc_result_t fwd_res;
	bycc_result_t inv_res;

	// Valid bits and stage enables shared by both datapaths.
	bycc_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel.valid),
		.in_ready  (pixel.ready),
		.func      (pixel.data.func),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.ctrl      (ctrl)
	);

	// Forward direction: BGR to YCrCb.
	bycc_fwd u_fwd (
		.clk   (clk),
		.en    (ctrl.en),
		.pixel (pixel.data),
		.res   (fwd_res)
	);

	// Inverse direction: YCrCb to BGR.
	bycc_inv u_inv (
		.clk   (clk),
		.en    (ctrl.en),
		.pixel (pixel.data),
		.res   (inv_res)
	);

	// The direction bit of the item in the last stage selects its result.
	assign result.data = (ctrl.func == FuncInv) ? inv_res : fwd_res;

endmodule
